@@ design/status_led_pattern_engine_top_defines.svh @@
// assertion helpers for the status led pattern engine
`ifndef STATUS_LED_PATTERN_ENGINE_TOP_DEFINES_SVH
`define STATUS_LED_PATTERN_ENGINE_TOP_DEFINES_SVH

// checked only outside reset
`define SLPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define SLPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ design/slpe_pkg.sv @@
package slpe_pkg;

    localparam int BREATH_TICKS = 2000;
    localparam int PHASE_W      = $clog2(BREATH_TICKS);

    // per-led modes
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_ON      = 3'd1;
    localparam logic [2:0] MODE_SLOW    = 3'd2;
    localparam logic [2:0] MODE_FAST    = 3'd3;
    localparam logic [2:0] MODE_SLOWEST = 3'd4;
    localparam logic [2:0] MODE_BREATH  = 3'd5;

    // opcodes
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // status codes, the rest are silent
    localparam logic [2:0] ST_IDLE         = 3'd0;
    localparam logic [2:0] ST_EXECUTING    = 3'd1;
    localparam logic [2:0] ST_QUESTION     = 3'd2;
    localparam logic [2:0] ST_ERROR        = 3'd3;
    localparam logic [2:0] ST_DISCONNECTED = 3'd4;

    // register indexes
    localparam logic [1:0] REG_ACTIVE_HIGH  = 2'd0;
    localparam logic [1:0] REG_SLOW_HALF    = 2'd1;
    localparam logic [1:0] REG_FAST_HALF    = 2'd2;
    localparam logic [1:0] REG_SLOWEST_HALF = 2'd3;

    localparam logic [15:0] SLOW_HALF_RST    = 16'd500;
    localparam logic [15:0] FAST_HALF_RST    = 16'd250;
    localparam logic [15:0] SLOWEST_HALF_RST = 16'd800;
    localparam logic [7:0]  DUTY_FULL        = 8'd255;

    localparam logic [63:0] Q_ONE       = 64'd1 << 50;
    localparam logic [63:0] HALF_PI_Q50 = 64'h6487ED5110B46;

    // taylor denominators (2k)(2k+1) for k = 1..12, entry 0 is k = 1
    localparam logic [11:0][9:0] TAYLOR_DEN = {
        10'd600, 10'd506, 10'd420, 10'd342, 10'd272, 10'd210,
        10'd156, 10'd110, 10'd72,  10'd42,  10'd20,  10'd6
    };

    typedef struct packed {
        logic       opcode;
        logic [2:0] status;
    } slpe_in_t;

    typedef struct packed {
        logic [7:0] green_level;
        logic       green_analog;
        logic       yellow_pin;
        logic       red_pin;
    } slpe_out_t;

    typedef logic [BREATH_TICKS-1:0][7:0] breath_rom_t;

    // (a*b) >> 50, elaboration only
    function automatic logic [63:0] mul_q50(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[113:50];
    endfunction

    // sin(pi/2 * m / BREATH_TICKS) in q50
    function automatic logic [63:0] quarter_sine(input logic [31:0] m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x = (HALF_PI_Q50 * {32'd0, m}) / BREATH_TICKS;
        x2 = mul_q50(x, x);
        term = x;
        sum = x;
        for (int k = 1; k <= 12; k++) begin
            term = mul_q50(term, x2) / TAYLOR_DEN[k - 1];
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // floor((sin(2*pi*e/P)+1)/2*255)
    function automatic logic [7:0] breath_value(input logic [31:0] e);
        logic [31:0] u;
        logic [31:0] q;
        logic [31:0] r;
        logic [31:0] m;
        logic [63:0] s;
        logic [63:0] t;
        u = 4 * e;
        q = u / BREATH_TICKS;
        r = u % BREATH_TICKS;
        m = q[0] ? (32'(BREATH_TICKS) - r) : r;
        if (m >= 32'(BREATH_TICKS)) begin
            s = Q_ONE;
        end else begin
            s = quarter_sine(m);
            if (s >= Q_ONE) begin
                s = Q_ONE - 64'd1;
            end
        end
        if (q < 32'd2) begin
            t = (Q_ONE + s) * 64'd255;
        end else begin
            t = (Q_ONE - s) * 64'd255;
        end
        return t[58:51];
    endfunction

    function automatic breath_rom_t build_breath_rom();
        breath_rom_t rom;
        for (int e = 0; e < BREATH_TICKS; e++) begin
            rom[e] = breath_value(32'(e));
        end
        return rom;
    endfunction

endpackage

@@ design/status_led_pattern_engine_top.sv @@
// channel   | ports                        | beat
// ----------+------------------------------+------------------------------------
// input     | s_valid s_ready s_data       | opcode (set / tick), status code
// result    | m_valid m_ready m_data       | green level, green analog, yellow, red
// config    | psel penable pwrite paddr .. | polarity and three half-periods
//
// one beat in, one beat out; the result beat is registered from the input beat, and a new
// input beat can be taken every cycle while the result register drains.
// the breathing rom is read one phase ahead so a tick never waits on the rom port.
// synchronous active-low reset clears modes, counters, phase, duty and result valid, and loads the register defaults.
// a stalled result holds the input side only once the result register is full.
`include "status_led_pattern_engine_top_defines.svh"

module status_led_pattern_engine_top
    import slpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  slpe_in_t    s_data,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output slpe_out_t   m_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam breath_rom_t BreathRom = build_breath_rom();

    // configuration registers
    logic        active_high_reg;
    logic [15:0] slow_half_reg;
    logic [15:0] fast_half_reg;
    logic [15:0] slowest_half_reg;

    // led state
    logic [2:0]         mode_reg  [3];
    logic [2:0]         mode_next [3];
    logic               lit_reg   [3];
    logic               lit_next  [3];
    logic [15:0]        count_reg [3];
    logic [15:0]        count_next[3];
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [7:0]         duty_reg;
    logic [7:0]         duty_next;

    // rom holds the value for the phase after the current one
    logic [PHASE_W-1:0] rom_phase;
    logic [PHASE_W-1:0] rom_addr;
    logic [7:0]         rom_q_reg;

    // result register
    logic      m_valid_reg;
    slpe_out_t m_data_reg;
    slpe_out_t m_data_next;

    logic       in_accept;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [2:0] new_mode[3];
    logic [16:0] count_inc;
    logic [15:0] half_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    // result register frees itself when taken, so a beat can enter every cycle while results are taken
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // register read-back
    always_comb begin
        unique case (cfg_index)
            REG_ACTIVE_HIGH:  prdata = {31'd0, active_high_reg};
            REG_SLOW_HALF:    prdata = {16'd0, slow_half_reg};
            REG_FAST_HALF:    prdata = {16'd0, fast_half_reg};
            REG_SLOWEST_HALF: prdata = {16'd0, slowest_half_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // status code to per-led modes
    always_comb begin
        new_mode[0] = MODE_OFF;
        new_mode[1] = MODE_OFF;
        new_mode[2] = MODE_OFF;
        unique case (s_data.status)
            ST_IDLE:         new_mode[0] = MODE_BREATH;
            ST_EXECUTING:    new_mode[1] = MODE_ON;
            ST_QUESTION: begin
                new_mode[0] = MODE_SLOW;
                new_mode[1] = MODE_SLOW;
            end
            ST_ERROR:        new_mode[2] = MODE_SLOWEST;
            ST_DISCONNECTED: new_mode[2] = MODE_FAST;
            default: ;  // silent codes leave everything off
        endcase
    end

    // next state for one accepted beat
    always_comb begin
        phase_next = phase_reg;
        duty_next  = duty_reg;
        count_inc  = '0;
        half_sel   = '0;
        for (int i = 0; i < 3; i++) begin
            mode_next[i]  = mode_reg[i];
            lit_next[i]   = lit_reg[i];
            count_next[i] = count_reg[i];
        end
        if (in_accept) begin
            if (s_data.opcode == OP_SET) begin
                for (int i = 0; i < 3; i++) begin
                    mode_next[i]  = new_mode[i];
                    count_next[i] = '0;
                    lit_next[i]   = (new_mode[i] != MODE_OFF);
                end
                // question mode: yellow runs in antiphase to green
                if (s_data.status == ST_QUESTION) begin
                    lit_next[1] = 1'b0;
                end
                // breathing restarts at full raw duty
                if (new_mode[0] == MODE_BREATH) begin
                    phase_next = '0;
                    duty_next  = DUTY_FULL;
                end
            end else begin
                if (mode_reg[0] == MODE_BREATH) begin
                    phase_next = (phase_reg == PHASE_W'(BREATH_TICKS - 1)) ?
                                 '0 : phase_reg + 1'b1;
                    duty_next  = active_high_reg ? rom_q_reg : ~rom_q_reg;
                end
                for (int i = 0; i < 3; i++) begin
                    if (mode_reg[i] == MODE_SLOW || mode_reg[i] == MODE_FAST ||
                        mode_reg[i] == MODE_SLOWEST) begin
                        case (mode_reg[i])
                            MODE_SLOW: half_sel = slow_half_reg;
                            MODE_FAST: half_sel = fast_half_reg;
                            default:   half_sel = slowest_half_reg;
                        endcase
                        // a zero half-period acts as one
                        if (half_sel == '0) begin
                            half_sel = 16'd1;
                        end
                        count_inc = {1'b0, count_reg[i]} + 17'd1;
                        if (count_inc >= {1'b0, half_sel}) begin
                            lit_next[i]   = !lit_reg[i];
                            count_next[i] = '0;
                        end else begin
                            count_next[i] = count_inc[15:0];
                        end
                    end
                end
            end
        end
    end

    // result from the updated state, pins after polarity
    always_comb begin
        if (mode_next[0] == MODE_BREATH) begin
            m_data_next.green_level  = duty_next;
            m_data_next.green_analog = 1'b1;
        end else begin
            m_data_next.green_level  = (lit_next[0] ^ !active_high_reg) ? DUTY_FULL : 8'd0;
            m_data_next.green_analog = 1'b0;
        end
        m_data_next.yellow_pin = lit_next[1] ^ !active_high_reg;
        m_data_next.red_pin    = lit_next[2] ^ !active_high_reg;
    end

    // look one phase ahead of the phase being stored
    assign rom_phase = aresetn ? phase_next : '0;
    assign rom_addr  = (rom_phase == PHASE_W'(BREATH_TICKS - 1)) ? '0 : rom_phase + 1'b1;

    always_ff @(posedge aclk) begin
        rom_q_reg <= BreathRom[rom_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_high_reg  <= 1'b1;
            slow_half_reg    <= SLOW_HALF_RST;
            fast_half_reg    <= FAST_HALF_RST;
            slowest_half_reg <= SLOWEST_HALF_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_ACTIVE_HIGH:  active_high_reg  <= pwdata[0];
                REG_SLOW_HALF:    slow_half_reg    <= pwdata[15:0];
                REG_FAST_HALF:    fast_half_reg    <= pwdata[15:0];
                REG_SLOWEST_HALF: slowest_half_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                mode_reg[i]  <= MODE_OFF;
                lit_reg[i]   <= 1'b0;
                count_reg[i] <= '0;
            end
            phase_reg   <= '0;
            duty_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                mode_reg[i]  <= mode_next[i];
                lit_reg[i]   <= lit_next[i];
                count_reg[i] <= count_next[i];
            end
            phase_reg <= phase_next;
            duty_reg  <= duty_next;
            if (in_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    `SLPE_ASSERT(a_accept_gives_result, in_accept |=> m_valid, "accepted beat left no result")
    `SLPE_ASSERT(a_analog_matches_mode, m_valid |-> (m_data.green_analog == (mode_reg[0] == MODE_BREATH)), "green analog flag disagrees with green mode")
    `SLPE_ASSERT(a_phase_in_range, phase_reg < PHASE_W'(BREATH_TICKS), "breath phase out of range")
    `SLPE_ASSERT(a_only_green_breathes, (mode_reg[1] != MODE_BREATH) && (mode_reg[2] != MODE_BREATH), "yellow or red in breathing mode")
    `SLPE_ASSERT(a_steady_count_idle, (mode_reg[1] == MODE_OFF || mode_reg[1] == MODE_ON) |-> (count_reg[1] == '0), "blink counter moved on a steady led")

endmodule

@@ bench/status_led_checker.sv @@
`timescale 1ns / 100ps

module status_led_checker
    import slpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  slpe_in_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  slpe_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          pending,
    output int          mismatches
);

    localparam int SHOWN = 10;

    // register copies
    logic        polarity_high;
    logic [15:0] half_slow;
    logic [15:0] half_fast;
    logic [15:0] half_slowest;

    // led state
    logic [2:0]  led_mode [3];
    logic        led_lit [3];
    logic [15:0] blink_count [3];
    int unsigned breath_phase;
    logic [7:0]  green_duty;

    logic [7:0]  breath_curve [BREATH_TICKS];
    slpe_out_t   expected_leds [$];

    initial pending = 0;
    initial mismatches = 0;

    function automatic logic [63:0] q50_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return 64'(wide >> 50);
    endfunction

    // one full period of the breathing curve, sine by taylor series per quadrant
    initial begin
        logic [63:0] x;
        logic [63:0] xx;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] scaled;
        int unsigned quad;
        int unsigned rem;
        int unsigned m;
        for (int e = 0; e < BREATH_TICKS; e++) begin
            quad = (4 * e) / BREATH_TICKS;
            rem  = (4 * e) % BREATH_TICKS;
            m    = (quad % 2 == 1) ? BREATH_TICKS - rem : rem;
            if (m >= BREATH_TICKS) begin
                acc = Q_ONE;
            end else begin
                x    = (HALF_PI_Q50 * 64'(m)) / 64'(BREATH_TICKS);
                xx   = q50_mul(x, x);
                term = x;
                acc  = x;
                for (int k = 1; k <= 12; k++) begin
                    term = q50_mul(term, xx) / 64'(2 * k * (2 * k + 1));
                    if (k % 2 == 1) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
                if (acc >= Q_ONE) begin
                    acc = Q_ONE - 64'd1;
                end
            end
            scaled = (quad < 2) ? (Q_ONE + acc) * 64'd255 : (Q_ONE - acc) * 64'd255;
            breath_curve[e] = scaled[58:51];
        end
    end

    always @(posedge aclk) begin
        slpe_out_t   want;
        slpe_out_t   got;
        logic [2:0]  chosen [3];
        logic [15:0] half;
        logic [16:0] next_count;
        if (!aresetn) begin
            polarity_high = 1'b1;
            half_slow     = SLOW_HALF_RST;
            half_fast     = FAST_HALF_RST;
            half_slowest  = SLOWEST_HALF_RST;
            for (int i = 0; i < 3; i++) begin
                led_mode[i]    = MODE_OFF;
                led_lit[i]     = 1'b0;
                blink_count[i] = '0;
            end
            breath_phase = 0;
            green_duty   = '0;
            expected_leds.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_leds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN) begin
                        $display("%0t: result beat with nothing expected: level %0d analog %0b yellow %0b red %0b",
                                 $realtime, got.green_level, got.green_analog, got.yellow_pin,
                                 got.red_pin);
                    end
                end else begin
                    want = expected_leds.pop_front();
                    if (got.green_level !== want.green_level
                            || got.green_analog !== want.green_analog
                            || got.yellow_pin !== want.yellow_pin
                            || got.red_pin !== want.red_pin) begin
                        mismatches++;
                        if (mismatches <= SHOWN) begin
                            $display("%0t: expected level %0d analog %0b yellow %0b red %0b",
                                     $realtime, want.green_level, want.green_analog,
                                     want.yellow_pin, want.red_pin);
                            $display("%0t:   actual level %0d analog %0b yellow %0b red %0b",
                                     $realtime, got.green_level, got.green_analog,
                                     got.yellow_pin, got.red_pin);
                        end
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (s_data.opcode == OP_SET) begin
                    for (int i = 0; i < 3; i++) begin
                        chosen[i] = MODE_OFF;
                    end
                    case (s_data.status)
                        ST_IDLE: begin
                            chosen[0] = MODE_BREATH;
                        end
                        ST_EXECUTING: begin
                            chosen[1] = MODE_ON;
                        end
                        ST_QUESTION: begin
                            chosen[0] = MODE_SLOW;
                            chosen[1] = MODE_SLOW;
                        end
                        ST_ERROR: begin
                            chosen[2] = MODE_SLOWEST;
                        end
                        ST_DISCONNECTED: begin
                            chosen[2] = MODE_FAST;
                        end
                        default: begin
                        end
                    endcase
                    for (int i = 0; i < 3; i++) begin
                        led_mode[i]    = chosen[i];
                        blink_count[i] = '0;
                        led_lit[i]     = (chosen[i] != MODE_OFF);
                        if (chosen[i] == MODE_BREATH) begin
                            breath_phase = 0;
                            green_duty   = DUTY_FULL;
                        end
                    end
                    // question: yellow blinks opposite to green
                    if (s_data.status == ST_QUESTION) begin
                        led_lit[1] = ~led_lit[0];
                    end
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (led_mode[i] == MODE_BREATH) begin
                            breath_phase = (breath_phase + 1) % BREATH_TICKS;
                            green_duty = polarity_high ? breath_curve[breath_phase]
                                                       : DUTY_FULL - breath_curve[breath_phase];
                        end else if (led_mode[i] == MODE_SLOW || led_mode[i] == MODE_FAST
                                     || led_mode[i] == MODE_SLOWEST) begin
                            case (led_mode[i])
                                MODE_SLOW: half = half_slow;
                                MODE_FAST: half = half_fast;
                                default:   half = half_slowest;
                            endcase
                            if (half == 16'd0) begin
                                half = 16'd1;
                            end
                            next_count = {1'b0, blink_count[i]} + 17'd1;
                            if (next_count >= {1'b0, half}) begin
                                led_lit[i] = ~led_lit[i];
                                next_count = '0;
                            end
                            blink_count[i] = next_count[15:0];
                        end
                    end
                end
                want.green_analog = (led_mode[0] == MODE_BREATH);
                if (want.green_analog) begin
                    want.green_level = green_duty;
                end else begin
                    want.green_level = (led_lit[0] ^ ~polarity_high) ? DUTY_FULL : 8'd0;
                end
                want.yellow_pin = led_lit[1] ^ ~polarity_high;
                want.red_pin    = led_lit[2] ^ ~polarity_high;
                expected_leds.push_back(want);
            end

            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ACTIVE_HIGH:  polarity_high = pwdata[0];
                    REG_SLOW_HALF:    half_slow     = pwdata[15:0];
                    REG_FAST_HALF:    half_fast     = pwdata[15:0];
                    REG_SLOWEST_HALF: half_slowest  = pwdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
        pending <= expected_leds.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import slpe_pkg::*;

    localparam int RANDOM_BEATS = 300;   // random part of the stimulus
    localparam int HOLD_CYCLES  = 64;    // long result stall, enough to back up the input
    localparam int SWEEP_FIRST  = 100;   // breathing ticks before the polarity flip
    localparam int SWEEP_SECOND = 100;   // breathing ticks after the polarity flip

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    slpe_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    slpe_out_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   pending;
    int   mismatches;
    int   sent = 0;
    // no idling on either side while set
    logic quiet = 1'b0;
    // asks the result side for one long stall
    logic hold_results = 1'b0;

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    status_led_pattern_engine_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // watches all three ports, predicts the led pins and compares
    status_led_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pending    (pending),
        .mismatches (mismatches)
    );

    // idle cycles before the next beat on either side
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    // half-period for a random phase: mostly short so blinking toggles often,
    // sometimes zero (acts as one), one, or the largest value
    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            default: return 16'($urandom_range(2, 12));
        endcase
    endfunction

    // offer one input beat; valid stays up into the next beat when there is no gap
    task automatic send_beat(input logic op, input logic [2:0] code);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data.opcode <= op;
        s_data.status <= code;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // stop offering and wait until every expected result beat has come back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        // margin after the registered result beat
        repeat (4) @(posedge aclk);
    endtask

    // setup then access; psel stays up so writes can chain, the caller closes the bus
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // writes the registers selected by mask; callers must use it only while the block is idle, it does not enforce this
    task automatic load_settings(input logic [3:0] mask, input logic polarity,
                                 input logic [15:0] slow, input logic [15:0] fast,
                                 input logic [15:0] slowest);
        if (mask[REG_ACTIVE_HIGH]) begin
            reg_write(REG_ACTIVE_HIGH, {31'd0, polarity});
        end
        if (mask[REG_SLOW_HALF]) begin
            reg_write(REG_SLOW_HALF, {16'd0, slow});
        end
        if (mask[REG_FAST_HALF]) begin
            reg_write(REG_FAST_HALF, {16'd0, fast});
        end
        if (mask[REG_SLOWEST_HALF]) begin
            reg_write(REG_SLOWEST_HALF, {16'd0, slowest});
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: random stalls per beat, one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // stimulus
    initial begin
        int random_start;
        int phase_end;
        int run_len;
        int phase;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings: every status code, status bits ignored on ticks
        send_beat(OP_TICK, 3'b111);
        send_beat(OP_SET, ST_IDLE);          // raw full duty right after the set
        send_beat(OP_TICK, 3'b000);
        send_beat(OP_TICK, 3'b101);
        send_beat(OP_SET, ST_EXECUTING);
        send_beat(OP_TICK, 3'b010);
        send_beat(OP_SET, ST_QUESTION);
        send_beat(OP_TICK, 3'b111);
        send_beat(OP_SET, ST_ERROR);
        send_beat(OP_TICK, 3'b001);
        send_beat(OP_SET, ST_DISCONNECTED);
        send_beat(OP_TICK, 3'b100);
        // the silent codes above the named ones
        for (int code = ST_DISCONNECTED + 1; code < 8; code++) begin
            send_beat(OP_SET, 3'(code));
        end

        // shortest half-periods, slowest set to zero which toggles every tick
        settle();
        load_settings(4'b1111, 1'b1, 16'd1, 16'd2, 16'd0);
        send_beat(OP_SET, ST_QUESTION);
        repeat (3) send_beat(OP_TICK, 3'b000);
        send_beat(OP_SET, ST_DISCONNECTED);
        repeat (2) send_beat(OP_TICK, 3'b110);
        send_beat(OP_SET, ST_ERROR);
        repeat (2) send_beat(OP_TICK, 3'b011);

        // polarity flip shows on the pins with the next beat, then breathing ticks
        // under both polarities
        settle();
        load_settings(4'b0001, 1'b0, 16'd0, 16'd0, 16'd0);
        send_beat(OP_TICK, 3'b000);
        send_beat(OP_SET, ST_IDLE);
        repeat (SWEEP_FIRST) send_beat(OP_TICK, 3'($urandom_range(0, 7)));
        settle();
        load_settings(4'b0001, 1'b1, 16'd0, 16'd0, 16'd0);
        repeat (SWEEP_SECOND) send_beat(OP_TICK, 3'($urandom_range(0, 7)));

        // random phases: new settings between phases while idle, counters carry over
        // so a lowered half-period can catch a counter past it
        random_start = sent;
        phase = 0;
        while (sent - random_start < RANDOM_BEATS) begin
            settle();
            load_settings(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1)),
                          pick_half(), pick_half(), pick_half());
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // back-to-back beats against a long result stall
                quiet = 1'b1;
                hold_results = 1'b1;
            end
            phase_end = sent + $urandom_range(30, 60);
            while (sent < phase_end) begin
                if ($urandom_range(0, 3) != 0) begin
                    // a status change followed by a run of ticks
                    send_beat(OP_SET, 3'($urandom_range(0, 7)));
                    run_len = $urandom_range(2, 24);
                    repeat (run_len) send_beat(OP_TICK, 3'($urandom_range(0, 7)));
                end else begin
                    send_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
                end
            end
            phase++;
        end
        quiet = 1'b0;

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(20_000_000);
        $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/slpe_pkg.sv
design/status_led_pattern_engine_top.sv
bench/status_led_checker.sv
bench/testbench.sv
